// ===== rtl/assert_macros.svh =====
// assertion macros for the port-level checker jfsh_checker of this project
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true on a clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/jfsh_pkg.sv =====
// types and constants of the jpeg frame/scan header parser
// used by jfsh_step, the top level and the testbench; no dependencies
`default_nettype none

package jfsh_pkg;

  localparam int MAX_COMPONENTS = 3;
  localparam int COUNT_LIMIT    = (MAX_COMPONENTS < 3) ? MAX_COMPONENTS : 3;

  // segment kinds as tagged on the first byte
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_SCAN  = 2'd1;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_COUNT      = 3'd1,
    ERR_ID         = 3'd2,
    ERR_SAMPLING   = 3'd3,
    ERR_SCAN_COUNT = 3'd4,
    ERR_SHORT      = 3'd5
  } err_e;

  typedef enum logic [14:0] {
    PH_IDLE    = 15'b000000000000001,
    PH_LEN_LO  = 15'b000000000000010,
    PH_PREC    = 15'b000000000000100,
    PH_H_HI    = 15'b000000000001000,
    PH_H_LO    = 15'b000000000010000,
    PH_W_HI    = 15'b000000000100000,
    PH_W_LO    = 15'b000000001000000,
    PH_F_COUNT = 15'b000000010000000,
    PH_F_ID    = 15'b000000100000000,
    PH_F_SAMP  = 15'b000001000000000,
    PH_F_QUANT = 15'b000010000000000,
    PH_S_COUNT = 15'b000100000000000,
    PH_S_ID    = 15'b001000000000000,
    PH_S_TAB   = 15'b010000000000000,
    PH_DRAIN   = 15'b100000000000000
  } phase_e;

  // one component entry, v in the lowest bits
  typedef struct packed {
    logic [1:0] dc;
    logic [2:0] ac;
    logic [1:0] quant;
    logic [1:0] h;
    logic [1:0] v;
  } entry_t;

  typedef struct packed {
    logic            done;
    err_e            err;
    logic [7:0]      precision;
    logic [15:0]     height;
    logic [15:0]     width;
    logic [1:0]      count;
    entry_t [2:0]    entries;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic [1:0] kind;
  } byte_t;

endpackage

`default_nettype wire

// ===== rtl/jpeg_frame_scan_header_parser.sv =====
// jpeg frame/scan header parser, top level: input register, parser step, result register
// depends on jfsh_pkg and jfsh_step
//
// Parses the payload bytes of a jpeg marker segment, one byte per word,
// beginning with the two big-endian length bytes (flagged by first_byte on
// the first). segment_kind, taken with the first byte, selects a frame
// header (precision, height, width, up to three components with sampling
// factors and quant table), a scan header (count must match the frame, then
// huffman table selectors per component) or a segment that is only skipped
// by its length. Every input word yields exactly one output word carrying
// the stored header fields after that byte; tlast marks the byte that ends
// the segment, normally or on error, and tuser carries the error code.
// Throughput is one byte per clock while the output accepts: the whole per-byte
// update is a single phase step between the input register and the result
// register, and the input register still takes a byte while a result waits.
// Each byte passes the input register and then the result register before
// its result word goes valid. A stalled output holds one result and one
// further byte in the input register before tready drops.
`default_nettype none

module jpeg_frame_scan_header_parser import jfsh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // data_byte[7:0]
  input  wire logic [2:0]  s_axis_tuser_i,   // first_byte[0], segment_kind[2:1]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [79:0]      m_axis_tdata_o,   // precision[7:0], image_height[23:8],
                                             // image_width[39:24], component_count[41:40],
                                             // component_table[74:42], zero[79:75]
  output logic [2:0]       m_axis_tuser_o,   // error_code[2:0]
  output logic             m_axis_tlast_o    // segment_done
);

  // input register
  logic    in_valid_q;
  byte_t   in_q;
  // result register
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    step;
  logic    in_accept;

  // a byte moves into the parser when the result slot is free or draining
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.data  <= s_axis_tdata_i;
      in_q.first <= s_axis_tuser_i[0];
      in_q.kind  <= s_axis_tuser_i[2:1];
    end
  end

  jfsh_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_q.done;
  assign m_axis_tuser_o  = out_q.err;
  assign m_axis_tdata_o  = {5'd0, out_q.entries, out_q.count, out_q.width,
                            out_q.height, out_q.precision};

endmodule

`default_nettype wire

// ===== rtl/jfsh_step.sv =====
// parser state and single-pass phase update for one segment byte
// depends on jfsh_pkg
`default_nettype none

module jfsh_step import jfsh_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,   // consume byte_i this cycle
  input  wire byte_t   byte_i,
  output result_t      res_o     // result of the byte, state after update
);

  phase_e       phase_q, phase_d, nxt;
  logic [15:0]  len_q, len_d;
  logic [15:0]  seen_q, seen_d;
  logic [7:0]   hold_q, hold_d;
  logic [1:0]   idx_q, idx_d;
  logic [1:0]   loop_q, loop_d, loop_inc;
  logic [7:0]   prec_q, prec_d;
  logic [15:0]  height_q, height_d;
  logic [15:0]  width_q, width_d;
  logic [1:0]   count_q, count_d;
  entry_t [2:0] ent_q, ent_d;
  err_e         err;
  logic         done;
  logic [7:0]   b;
  logic [3:0]   samp_v, samp_h;

  assign b        = byte_i.data;
  assign loop_inc = loop_q + 2'd1;
  assign samp_v   = b[3:0];
  assign samp_h   = b[7:4];

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    seen_d   = seen_q;
    hold_d   = hold_q;
    idx_d    = idx_q;
    loop_d   = loop_q;
    prec_d   = prec_q;
    height_d = height_q;
    width_d  = width_q;
    count_d  = count_q;
    ent_d    = ent_q;
    nxt      = PH_IDLE;
    err      = ERR_NONE;
    done     = 1'b0;
    if (byte_i.first) begin
      phase_d = PH_LEN_LO;
      hold_d  = b;
      seen_d  = 16'd1;
      len_d   = 16'd0;
      idx_d   = byte_i.kind;
      loop_d  = 2'd0;
    end else if (phase_q != PH_IDLE) begin
      seen_d = seen_q + 16'd1;
      case (phase_q)
        PH_LEN_LO: begin
          len_d = {hold_q, b};
          if (idx_q == KIND_FRAME) begin
            nxt = PH_PREC;
          end else if (idx_q == KIND_SCAN) begin
            nxt = PH_S_COUNT;
          end else begin
            nxt = PH_DRAIN;
          end
          idx_d = 2'd0;
        end
        PH_PREC: begin
          prec_d = b;
          nxt    = PH_H_HI;
        end
        PH_H_HI: begin
          hold_d = b;
          nxt    = PH_H_LO;
        end
        PH_H_LO: begin
          height_d = {hold_q, b};
          nxt      = PH_W_HI;
        end
        PH_W_HI: begin
          hold_d = b;
          nxt    = PH_W_LO;
        end
        PH_W_LO: begin
          width_d = {hold_q, b};
          nxt     = PH_F_COUNT;
        end
        PH_F_COUNT: begin
          if (b > 8'(COUNT_LIMIT)) begin
            err = ERR_COUNT;
          end else begin
            count_d = b[1:0];
            loop_d  = 2'd0;
            nxt     = (b == 8'd0) ? PH_DRAIN : PH_F_ID;
          end
        end
        PH_S_COUNT: begin
          if (b != {6'd0, count_q}) begin
            err = ERR_SCAN_COUNT;
          end else begin
            loop_d = 2'd0;
            nxt    = (b == 8'd0) ? PH_DRAIN : PH_S_ID;
          end
        end
        PH_F_ID, PH_S_ID: begin
          if (b == 8'd0 || b > 8'd3) begin
            err = ERR_ID;
          end else begin
            idx_d = b[1:0] - 2'd1;
            nxt   = (phase_q == PH_F_ID) ? PH_F_SAMP : PH_S_TAB;
          end
        end
        PH_F_SAMP: begin
          if (samp_v > 4'd2 || samp_h > 4'd2) begin
            err = ERR_SAMPLING;
          end else begin
            if (idx_q != 2'd3) begin
              ent_d[idx_q].v = samp_v[1:0];
              ent_d[idx_q].h = samp_h[1:0];
            end
            nxt = PH_F_QUANT;
          end
        end
        PH_F_QUANT, PH_S_TAB: begin
          if (idx_q != 2'd3) begin
            if (phase_q == PH_F_QUANT) begin
              ent_d[idx_q].quant = b[1:0];
            end else begin
              ent_d[idx_q].ac = {1'b1, b[1:0]};
              ent_d[idx_q].dc = b[5:4];
            end
          end
          loop_d = loop_inc;
          if (loop_inc >= count_q) begin
            nxt = PH_DRAIN;
          end else begin
            nxt = (phase_q == PH_F_QUANT) ? PH_F_ID : PH_S_ID;
          end
        end
        default: begin
          nxt = PH_DRAIN;
        end
      endcase

      if (err != ERR_NONE) begin
        done = 1'b1;
      end else if (seen_d >= len_d) begin
        done = 1'b1;
        // only a finished header meeting its length exactly ends cleanly
        if (!(nxt == PH_DRAIN && seen_d == len_d)) begin
          err = ERR_SHORT;
        end
      end
      phase_d = done ? PH_IDLE : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      len_q    <= '0;
      seen_q   <= '0;
      hold_q   <= '0;
      idx_q    <= '0;
      loop_q   <= '0;
      prec_q   <= '0;
      height_q <= '0;
      width_q  <= '0;
      count_q  <= '0;
      ent_q    <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      seen_q   <= seen_d;
      hold_q   <= hold_d;
      idx_q    <= idx_d;
      loop_q   <= loop_d;
      prec_q   <= prec_d;
      height_q <= height_d;
      width_q  <= width_d;
      count_q  <= count_d;
      ent_q    <= ent_d;
    end
  end

  always_comb begin
    res_o.done      = done;
    res_o.err       = err;
    res_o.precision = prec_d;
    res_o.height    = height_d;
    res_o.width     = width_d;
    res_o.count     = count_d;
    res_o.entries   = ent_d;
  end

endmodule

`default_nettype wire

// ===== rtl/jfsh_checker.sv =====
// port-level checks of the jpeg frame/scan header parser, bound to the top level
// depends on assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module jfsh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [79:0] m_axis_tdata_o,
  input wire logic [2:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // an error always ends the segment
  `ASSERT_NEVER(a_err_ends_segment, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o != 3'd0 && !m_axis_tlast_o, "error without segment end")

  // error codes stop at length short
  `ASSERT_NEVER(a_err_range, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o > 3'd5, "error code out of range")

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o), "stalled result changed")

  // a fresh result follows an accepted byte through the input and result registers
  `ASSERT_CLK(a_out_from_in, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2), "result without input byte")

endmodule

bind jpeg_frame_scan_header_parser jfsh_checker u_jfsh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

// ===== tb/jfsh_result_checker.sv =====
// checker for the jpeg frame/scan header parser: watches both stream channels,
// predicts each output word from the accepted input bytes and compares them
// depends on jfsh_pkg for the phase, error and result types
module jfsh_result_checker import jfsh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [79:0] m_tdata_i,
  input  logic [2:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          mismatch_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // parser state as the block should hold it
  phase_e       phase      = PH_IDLE;
  logic [15:0]  seg_len    = '0;
  logic [15:0]  seen       = '0;
  logic [7:0]   hi_hold    = '0;
  logic [1:0]   slot       = '0;
  logic [1:0]   comps_done = '0;
  logic [7:0]   prec       = '0;
  logic [15:0]  height     = '0;
  logic [15:0]  width      = '0;
  logic [1:0]   count      = '0;
  entry_t [2:0] entries    = '0;

  result_t predicted_words_q[$];
  int      mismatches = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = predicted_words_q.size();

  function automatic string describe(result_t r);
    return $sformatf("done %0d err %0d prec %h height %h width %h count %0d table %h",
                     r.done, r.err, r.precision, r.height, r.width, r.count, r.entries);
  endfunction

  // one byte step of the parser
  task automatic parse_byte(input byte_t w, output result_t r);
    phase_e     nxt;
    err_e       err;
    logic       done;
    logic [3:0] v_nib;
    logic [3:0] h_nib;
    nxt   = PH_IDLE;
    err   = ERR_NONE;
    done  = 1'b0;
    v_nib = w.data[3:0];
    h_nib = w.data[7:4];
    if (w.first) begin
      // a new segment, also abandons any segment in flight
      phase      = PH_LEN_LO;
      hi_hold    = w.data;
      seen       = 16'd1;
      seg_len    = '0;
      slot       = w.kind;
      comps_done = '0;
    end else if (phase != PH_IDLE) begin
      seen = seen + 16'd1;
      case (phase)
        PH_LEN_LO: begin
          seg_len = {hi_hold, w.data};
          if (slot == KIND_FRAME) nxt = PH_PREC;
          else if (slot == KIND_SCAN) nxt = PH_S_COUNT;
          else nxt = PH_DRAIN;
          slot = '0;
        end
        PH_PREC: begin
          prec = w.data;
          nxt  = PH_H_HI;
        end
        PH_H_HI: begin
          hi_hold = w.data;
          nxt     = PH_H_LO;
        end
        PH_H_LO: begin
          height = {hi_hold, w.data};
          nxt    = PH_W_HI;
        end
        PH_W_HI: begin
          hi_hold = w.data;
          nxt     = PH_W_LO;
        end
        PH_W_LO: begin
          width = {hi_hold, w.data};
          nxt   = PH_F_COUNT;
        end
        PH_F_COUNT: begin
          if (w.data > COUNT_LIMIT) begin
            err = ERR_COUNT;
          end else begin
            count      = w.data[1:0];
            comps_done = '0;
            nxt        = (w.data == 8'd0) ? PH_DRAIN : PH_F_ID;
          end
        end
        PH_S_COUNT: begin
          if (w.data != {6'd0, count}) begin
            err = ERR_SCAN_COUNT;
          end else begin
            comps_done = '0;
            nxt        = (w.data == 8'd0) ? PH_DRAIN : PH_S_ID;
          end
        end
        PH_F_ID, PH_S_ID: begin
          if (w.data == 8'd0 || w.data > 8'd3) begin
            err = ERR_ID;
          end else begin
            slot = w.data[1:0] - 2'd1;
            nxt  = (phase == PH_F_ID) ? PH_F_SAMP : PH_S_TAB;
          end
        end
        PH_F_SAMP: begin
          if (v_nib > 4'd2 || h_nib > 4'd2) begin
            err = ERR_SAMPLING;
          end else begin
            entries[slot].v = v_nib[1:0];
            entries[slot].h = h_nib[1:0];
            nxt = PH_F_QUANT;
          end
        end
        PH_F_QUANT, PH_S_TAB: begin
          if (phase == PH_F_QUANT) begin
            entries[slot].quant = w.data[1:0];
          end else begin
            // ac selector always carries bit 2
            entries[slot].ac = {1'b1, w.data[1:0]};
            entries[slot].dc = w.data[5:4];
          end
          comps_done = comps_done + 2'd1;
          if (comps_done >= count) nxt = PH_DRAIN;
          else nxt = (phase == PH_F_QUANT) ? PH_F_ID : PH_S_ID;
        end
        default: nxt = PH_DRAIN;
      endcase
      if (err != ERR_NONE) begin
        done = 1'b1;
      end else if (seen >= seg_len) begin
        done = 1'b1;
        if (!(nxt == PH_DRAIN && seen == seg_len)) err = ERR_SHORT;
      end
      phase = done ? PH_IDLE : nxt;
    end
    r.done      = done;
    r.err       = err;
    r.precision = prec;
    r.height    = height;
    r.width     = width;
    r.count     = count;
    r.entries   = entries;
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    byte_t   w;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        got.done      = m_tlast_i;
        got.err       = err_e'(m_tuser_i);
        got.precision = m_tdata_i[7:0];
        got.height    = m_tdata_i[23:8];
        got.width     = m_tdata_i[39:24];
        got.count     = m_tdata_i[41:40];
        got.entries   = m_tdata_i[74:42];
        if (predicted_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t unexpected output word: %s", $realtime, describe(got));
        end else begin
          want = predicted_words_q.pop_front();
          if (got.done !== want.done || got.err !== want.err ||
              got.precision !== want.precision || got.height !== want.height ||
              got.width !== want.width || got.count !== want.count ||
              got.entries[0] !== want.entries[0] || got.entries[1] !== want.entries[1] ||
              got.entries[2] !== want.entries[2]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        w.data  = s_tdata_i;
        w.first = s_tuser_i[0];
        w.kind  = s_tuser_i[2:1];
        parse_byte(w, want);
        predicted_words_q.push_back(want);
      end
    end
  end

endmodule

// ===== tb/jpeg_frame_scan_header_parser_test.sv =====
// stimulus and verdict for the jpeg frame/scan header parser
// builds marker segments byte by byte, drives them with random gaps and stalls;
// depends on jfsh_pkg, the parser top level and jfsh_result_checker
module jpeg_frame_scan_header_parser_test import jfsh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AT_WORD = 400;   // output word after which the receiver holds off
  localparam int HOLD_CYCLES  = 300;

  typedef logic [7:0] octets_t[$];

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid   = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata    = '0;
  logic [2:0]  s_axis_tuser    = '0;   // first_byte[0], segment_kind[2:1]
  logic        m_axis_tvalid;
  logic        m_axis_tready   = 1'b0;
  logic [79:0] m_axis_tdata;          // precision, height, width, count, component table
  logic [2:0]  m_axis_tuser;          // error code
  logic        m_axis_tlast;          // segment done

  int mismatches;
  int pending;
  int cycle_count = 0;

  byte_t segment_bytes_q[$];   // every byte to send, in order
  logic [1:0] last_frame_count = '0;  // count of the most recent frame, so scans mostly match

  always #1 clk_i = ~clk_i;

  jpeg_frame_scan_header_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  jfsh_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tuser_i        (m_axis_tuser),
    .m_tlast_i        (m_axis_tlast),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // length bytes first, then the body; kind is only sampled on the first byte,
  // so the other bytes carry a random kind
  task automatic add_segment(input logic [1:0] kind, input logic [15:0] len_field,
                             input octets_t body);
    segment_bytes_q.push_back(byte_t'{data: len_field[15:8], first: 1'b1, kind: kind});
    segment_bytes_q.push_back(byte_t'{data: len_field[7:0], first: 1'b0,
                                      kind: 2'($urandom)});
    foreach (body[i])
      segment_bytes_q.push_back(byte_t'{data: body[i], first: 1'b0, kind: 2'($urandom)});
  endtask

  // mostly the true length; sometimes short, sometimes longer so the next
  // segment cuts it off, now and then anything
  function automatic logic [15:0] pick_length(int natural);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return 16'(natural);
    if (r < 88) return 16'($urandom_range(0, natural - 1));
    if (r < 96) return 16'(natural + $urandom_range(1, 4));
    return 16'($urandom);
  endfunction

  // component id, mostly legal
  function automatic logic [7:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) return 8'($urandom_range(1, 3));
    if (r < 95) return 8'd0;
    return 8'($urandom_range(4, 255));
  endfunction

  task automatic add_frame();
    octets_t     body;
    int unsigned n;
    n = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 3) : $urandom_range(4, 255);
    repeat (5) body.push_back(8'($urandom));   // precision, height, width
    body.push_back(8'(n));
    if (n <= 3) begin
      last_frame_count = 2'(n);
      for (int i = 0; i < int'(n); i++) begin
        body.push_back(pick_id());
        if ($urandom_range(0, 99) < 88)
          body.push_back({4'($urandom_range(0, 2)), 4'($urandom_range(0, 2))});
        else
          body.push_back(8'($urandom));
        body.push_back(8'($urandom));   // quant table
      end
    end
    repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
    add_segment(KIND_FRAME, pick_length(body.size() + 2), body);
  endtask

  task automatic add_scan();
    octets_t     body;
    int unsigned n;
    n = ($urandom_range(0, 99) < 85) ? last_frame_count : $urandom_range(0, 4);
    body.push_back(8'(n));
    for (int i = 0; i < ((n > 3) ? 3 : int'(n)); i++) begin
      body.push_back(pick_id());
      body.push_back(8'($urandom));   // dc/ac selector byte
    end
    repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
    add_segment(KIND_SCAN, pick_length(body.size() + 2), body);
  endtask

  task automatic build_stimulus();
    octets_t     body;
    int unsigned r;
    int          directed;
    // stray byte while idle, ignored
    segment_bytes_q.push_back(byte_t'{data: 8'hff, first: 1'b0, kind: 2'd3});
    // kind three skipped, minimum length ends cleanly
    add_segment(2'd3, 16'd2, body);
    // frame with all-ones precision and height, zero width, one component id 3
    body = '{8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h01, 8'h03, 8'h22, 8'hff};
    add_segment(KIND_FRAME, 16'd11, body);
    // matching scan, widest table selectors
    body = '{8'h01, 8'h03, 8'hff};
    add_segment(KIND_SCAN, 16'd5, body);
    // scan whose count disagrees with the frame
    body = '{8'h02};
    add_segment(KIND_SCAN, 16'd5, body);
    // length below two
    body.delete();
    add_segment(KIND_FRAME, 16'd1, body);
    // huge length, abandoned by the next first byte
    body = '{8'h08};
    add_segment(KIND_FRAME, 16'hffff, body);
    last_frame_count = 2'd1;
    directed = segment_bytes_q.size();

    while (segment_bytes_q.size() < directed + RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        add_frame();
      end else if (r < 80) begin
        add_scan();
      end else begin
        body.delete();
        repeat ($urandom_range(0, 12)) body.push_back(8'($urandom));
        add_segment(($urandom_range(0, 3) == 0) ? 2'd3 : 2'd2,
                    pick_length(body.size() + 2), body);
      end
      // occasional noise between segments
      if ($urandom_range(0, 99) < 5)
        repeat ($urandom_range(1, 3))
          segment_bytes_q.push_back(byte_t'{data: 8'($urandom), first: 1'b0,
                                            kind: 2'($urandom)});
    end
  endtask

  // receiver: random stalls, bursts of full rate, one long hold-off to back up the block
  initial begin
    int  words_taken;
    int  gap;
    bit  burst;
    words_taken = 0;
    burst = 1'b0;
    wait (rst_ni);
    forever begin
      if (words_taken % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      words_taken++;
      if (words_taken == HOLD_AT_WORD) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
    end
  end

  // sender and verdict
  initial begin
    byte_t w;
    int    gap;
    int    sent;
    bit    burst;
    sent  = 0;
    burst = 1'b0;
    build_stimulus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    while (segment_bytes_q.size() > 0) begin
      w = segment_bytes_q.pop_front();
      if (sent % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= w.data;
      s_axis_tuser  <= {w.kind, w.first};
      do @(posedge clk_i); while (!s_axis_tready);
      sent++;
    end
    s_axis_tvalid <= 1'b0;

    // drain the outstanding words, then wait on for anything stray
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
